// ===== design/color_key_boundary_extractor_unit_defines.svh =====
// Assertion macros shared by the color key boundary extractor RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef COLOR_KEY_BOUNDARY_EXTRACTOR_UNIT_DEFINES_SVH
`define COLOR_KEY_BOUNDARY_EXTRACTOR_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define CKBE_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CKBE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define CKBE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ckbe_pkg.sv =====
// Package for the color key boundary extractor: sizes, register indexes,
// result and line store entry types, and the key compare function.
// No dependencies.
package ckbe_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	// compare width for column arithmetic, wide enough for the 12 bit width reg
	localparam int CMP_W      = (COL_W + 1 > 12) ? COL_W + 1 : 12;
	localparam int PIX_W      = 8;
	localparam int FW_W       = 12;
	localparam int FH_W       = 16;
	localparam int XW         = 11;
	localparam int YW         = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_RED      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_GREEN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_BLUE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ALPHA    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd6;

	typedef logic [COL_W-1:0] col_t;
	typedef logic [CMP_W-1:0] cmp_t;
	typedef logic [XW-1:0]    x_t;
	typedef logic [YW-1:0]    y_t;

	typedef struct packed {
		x_t   x;
		y_t   y;
		logic last;
	} res_t;

	// one line store entry: row two above and row above, same column
	typedef struct packed {
		logic prev2;
		logic prev;
	} mask_t;

	// strict signed compare of a channel against key minus tolerance
	function automatic logic above_key(logic [PIX_W-1:0] px, logic [PIX_W-1:0] key,
		logic [PIX_W-1:0] tol);
		logic signed [PIX_W+1:0] limit;
		logic signed [PIX_W+1:0] val;
		limit = $signed({2'b00, key}) - $signed({2'b00, tol});
		val   = $signed({2'b00, px});
		return val > limit;
	endfunction

endpackage

// ===== design/ckbe_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module ckbe_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== design/color_key_boundary_extractor_unit.sv =====
// Top level of the color key boundary extractor.
// Depends on ckbe_pkg, ckbe_ram and color_key_boundary_extractor_unit_defines.svh.
//
// Usage:
// - Input channel (in_valid/in_ready, red/green/blue/alpha): one RGBA pixel per
//   transaction, raster order, frame_width x frame_height pixels per frame.
// - Output channel (out_valid/out_ready, edge_x/edge_y/last_of_run): one boundary
//   coordinate per transaction; last_of_run marks the final result of a pixel.
//   Each pixel decides the pixel above it; pixels of the last row are decided
//   at once as well, so a last-row pixel can give two results.
// - Config port (cfg_wr_en/cfg_index/cfg_data): write only while no pixel is in
//   flight. Index 0..6: key red/green/blue/alpha, tolerance, width, height.
// - Result path: each accepted pixel is held in the input register; its results
//   enter the result queue, whose head drives the output channel.
// - Throughput: one pixel per cycle while out_ready stays high and each pixel
//   yields at most one result; else the output port sets the pace.
// - Reset: the line store (MAX_WIDTH entries) is cleared one entry a cycle,
//   with in_ready low; config writes are taken meanwhile.
// - Receiver stall: the two-entry result queue fills, then the input register
//   holds and in_ready drops until room opens.
module color_key_boundary_extractor_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// config
	input  logic                                cfg_wr_en,
	input  logic [ckbe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ckbe_pkg::CFG_DATA_W-1:0]     cfg_data,
	// pixel input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ckbe_pkg::PIX_W-1:0]          red,
	input  logic [ckbe_pkg::PIX_W-1:0]          green,
	input  logic [ckbe_pkg::PIX_W-1:0]          blue,
	input  logic [ckbe_pkg::PIX_W-1:0]          alpha,
	// boundary output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ckbe_pkg::XW-1:0]             edge_x,
	output logic [ckbe_pkg::YW-1:0]             edge_y,
	output logic                                last_of_run
);

`include "color_key_boundary_extractor_unit_defines.svh"

	// ---------------- config registers ----------------
	logic [ckbe_pkg::PIX_W-1:0] key_red_q, key_green_q, key_blue_q, key_alpha_q;
	logic [ckbe_pkg::PIX_W-1:0] tol_q;
	logic [ckbe_pkg::FW_W-1:0]  fw_q;
	logic [ckbe_pkg::FH_W-1:0]  fh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_red_q   <= 8'd255;
			key_green_q <= 8'd255;
			key_blue_q  <= 8'd255;
			key_alpha_q <= 8'd255;
			tol_q       <= 8'd15;
			fw_q        <= 12'd2048;
			fh_q        <= 16'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ckbe_pkg::REG_KEY_RED:      key_red_q   <= cfg_data[ckbe_pkg::PIX_W-1:0];
				ckbe_pkg::REG_KEY_GREEN:    key_green_q <= cfg_data[ckbe_pkg::PIX_W-1:0];
				ckbe_pkg::REG_KEY_BLUE:     key_blue_q  <= cfg_data[ckbe_pkg::PIX_W-1:0];
				ckbe_pkg::REG_KEY_ALPHA:    key_alpha_q <= cfg_data[ckbe_pkg::PIX_W-1:0];
				ckbe_pkg::REG_TOLERANCE:    tol_q       <= cfg_data[ckbe_pkg::PIX_W-1:0];
				ckbe_pkg::REG_FRAME_WIDTH:  fw_q        <= cfg_data[ckbe_pkg::FW_W-1:0];
				ckbe_pkg::REG_FRAME_HEIGHT: fh_q        <= cfg_data[ckbe_pkg::FH_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry: zero means one, width saturates at MAX_WIDTH
	ckbe_pkg::cmp_t            w_eff;
	logic [ckbe_pkg::FH_W-1:0] h_eff;
	ckbe_pkg::cmp_t            fw_ext;

	always_comb begin
		fw_ext = ckbe_pkg::cmp_t'(fw_q);
		if (fw_ext == '0) begin
			w_eff = ckbe_pkg::cmp_t'(1);
		end else if (fw_ext > ckbe_pkg::cmp_t'(ckbe_pkg::MAX_WIDTH)) begin
			w_eff = ckbe_pkg::cmp_t'(ckbe_pkg::MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
		h_eff = (fh_q == '0) ? ckbe_pkg::FH_W'(1) : fh_q;
	end

	// ---------------- line store clearing pass ----------------
	logic           clr_active_q;
	ckbe_pkg::col_t clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + ckbe_pkg::col_t'(1);
			if (clr_addr_q == ckbe_pkg::col_t'(ckbe_pkg::MAX_WIDTH - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// ---------------- position counters ----------------
	ckbe_pkg::col_t        col_q;
	logic [ckbe_pkg::YW-1:0] row_q;
	logic                  accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (ckbe_pkg::cmp_t'(col_q) + ckbe_pkg::cmp_t'(1) >= w_eff) begin
				col_q <= '0;
				if ({1'b0, row_q} + 17'd1 >= {1'b0, h_eff}) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 16'd1;
				end
			end else begin
				col_q <= col_q + ckbe_pkg::col_t'(1);
			end
		end
	end

	// ---------------- stage 1: pixel register ----------------
	logic                       s1_valid_q;
	logic [ckbe_pkg::PIX_W-1:0] red_s1, green_s1, blue_s1, alpha_s1;
	ckbe_pkg::col_t             x_s1;
	logic [ckbe_pkg::YW-1:0]    y_s1;
	logic                       s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			alpha_s1 <= alpha;
			x_s1     <= col_q;
			y_s1     <= row_q;
		end
	end

	// ---------------- line store ----------------
	// port A reads column x (row above, row two above), port B column x+1.
	logic              ram_we;
	ckbe_pkg::col_t    ram_waddr;
	ckbe_pkg::mask_t   ram_wdata;
	ckbe_pkg::mask_t   rd_a, rd_b;

	ckbe_ram #(
		.WIDTH($bits(ckbe_pkg::mask_t)),
		.DEPTH(ckbe_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (accept),
		.raddr_a (col_q),
		.raddr_b (col_q + ckbe_pkg::col_t'(1)),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// last write, forwarded over read data taken at the same edge as that write
	logic            lw_valid_q;
	ckbe_pkg::col_t  lw_addr_q;
	ckbe_pkg::mask_t lw_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (ram_we) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			lw_addr_q <= ram_waddr;
			lw_data_q <= ram_wdata;
		end
	end

	// left neighbour of the pixel above = that pixel's row-above bit one step ago
	logic left_q;

	// ---------------- stage 1 decision ----------------
	ckbe_pkg::mask_t ent_a, ent_b;
	ckbe_pkg::col_t  x_s1_p1;
	ckbe_pkg::cmp_t  x_plus;
	logic            mid, up, right_nb, cur, last_row, in_core, interior;
	logic            r0_v, r1_v;
	logic [1:0]      n_res;

	always_comb begin
		x_s1_p1 = x_s1 + ckbe_pkg::col_t'(1);
		ent_a   = (lw_valid_q && lw_addr_q == x_s1)    ? lw_data_q : rd_a;
		ent_b   = (lw_valid_q && lw_addr_q == x_s1_p1) ? lw_data_q : rd_b;
		mid      = ent_a.prev;
		up       = ent_a.prev2;
		right_nb = ent_b.prev;
		cur = !(ckbe_pkg::above_key(red_s1, key_red_q, tol_q)
			&& ckbe_pkg::above_key(green_s1, key_green_q, tol_q)
			&& ckbe_pkg::above_key(blue_s1, key_blue_q, tol_q)
			&& ckbe_pkg::above_key(alpha_s1, key_alpha_q, tol_q));
		last_row = ({1'b0, y_s1} + 17'd1) >= {1'b0, h_eff};
		x_plus   = ckbe_pkg::cmp_t'(x_s1) + ckbe_pkg::cmp_t'(1);
		in_core  = (x_s1 != '0) && (x_plus < w_eff) && (y_s1 >= 16'd2) && (y_s1 < h_eff);
		interior = in_core && up && cur && left_q && right_nb;
		r0_v     = (y_s1 != '0) && mid && !interior;
		r1_v     = last_row && cur;
		n_res    = {1'b0, r0_v} + {1'b0, r1_v};
	end

	// ---------------- result queue (two entries) ----------------
	ckbe_pkg::res_t q_q [2];
	logic [1:0]     q_cnt_q;
	ckbe_pkg::res_t q_nxt [2];
	logic [1:0]     cnt_nxt;
	logic [1:0]     q_base;
	logic           pop;
	logic           room;
	ckbe_pkg::res_t res_a, res_b;

	assign pop = (q_cnt_q != 2'd0) && out_ready;
	assign q_base = q_cnt_q - {1'b0, pop};
	assign room = ({1'b0, q_base} + {1'b0, n_res}) <= 3'd2;
	assign s1_adv = s1_valid_q && room;
	assign in_ready = !clr_active_q && (!s1_valid_q || s1_adv);

	always_comb begin
		res_b.x    = ckbe_pkg::x_t'(x_s1);
		res_b.y    = y_s1;
		res_b.last = 1'b1;
		if (r0_v) begin
			res_a.x    = ckbe_pkg::x_t'(x_s1);
			res_a.y    = y_s1 - 16'd1;
			res_a.last = !r1_v;
		end else begin
			res_a = res_b;
		end
	end

	always_comb begin
		q_nxt   = q_q;
		cnt_nxt = q_base;
		if (pop) begin
			q_nxt[0] = q_q[1];
		end
		if (s1_adv) begin
			if (n_res != 2'd0) begin
				q_nxt[q_base[0]] = res_a;
			end
			if (n_res == 2'd2) begin
				q_nxt[1] = res_b;
			end
			cnt_nxt = q_base + n_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0;
			left_q  <= 1'b0;
		end else begin
			q_cnt_q <= cnt_nxt;
			if (s1_adv) begin
				left_q <= mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_nxt;
	end

	// line store write: clearing pass, else the pixel leaving stage 1
	always_comb begin
		ram_we = clr_active_q || s1_adv;
		if (clr_active_q) begin
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_waddr       = x_s1;
			ram_wdata.prev2 = mid;
			ram_wdata.prev  = cur;
		end
	end

	assign out_valid   = q_cnt_q != 2'd0;
	assign edge_x      = q_q[0].x;
	assign edge_y      = q_q[0].y;
	assign last_of_run = q_q[0].last;

	// ---------------- assertions ----------------
	`CKBE_ASSERT_IMP(a_no_accept_in_clear, in_valid && in_ready, !clr_active_q, "taken in clear")
	`CKBE_ASSERT(a_queue_bound, q_cnt_q <= 2'd2, "result queue overflow")
	`CKBE_ASSERT_NXT(a_s1_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(x_s1), "s1 lost")
	`CKBE_ASSERT_IMP(a_clear_length, $fell(clr_active_q), $past(clr_addr_q) == '1, "short clear")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for color_key_boundary_extractor_unit: directed and random pixel
// frames through a valid/ready pipe, with a scoreboard that predicts each boundary coordinate.
// Depends on ckbe_pkg and the unit RTL.
module tb_top;

	// cycles with no transaction on either channel before the run is declared hung;
	// covers the line store clearing pass after reset with plenty of margin
	localparam int QUIET_LIMIT   = 10000;
	localparam int RANDOM_PIXELS = 400;

	localparam logic [ckbe_pkg::CFG_IDX_W-1:0] KEY_REGS [4] =
		'{ckbe_pkg::REG_KEY_RED, ckbe_pkg::REG_KEY_GREEN, ckbe_pkg::REG_KEY_BLUE,
		ckbe_pkg::REG_KEY_ALPHA};

	// one pixel, [0] red .. [3] alpha, same channel order as the key registers
	typedef logic [3:0][ckbe_pkg::PIX_W-1:0] rgba_t;

	// Boundary predictor plus queue of coordinates still owed by the unit.
	class edge_scoreboard;
		logic [ckbe_pkg::PIX_W-1:0] key [4];
		logic [ckbe_pkg::PIX_W-1:0] tol;
		logic [ckbe_pkg::FW_W-1:0]  width_reg;
		logic [ckbe_pkg::FH_W-1:0]  height_reg;
		bit                         fg_above [ckbe_pkg::MAX_WIDTH];
		bit                         fg_two_above [ckbe_pkg::MAX_WIDTH];
		int unsigned                col;
		int unsigned                row;
		ckbe_pkg::res_t             edges_due [$];
		int                         errors;
		int                         matched;
		int                         pixels;

		function new();
			foreach (key[i]) key[i] = 8'd255;
			tol        = 8'd15;
			width_reg  = 12'd2048;
			height_reg = 16'd1;
			col        = 0;
			row        = 0;
			errors     = 0;
			matched    = 0;
			pixels     = 0;
		endfunction

		function int unsigned eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > ckbe_pkg::MAX_WIDTH) return ckbe_pkg::MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function void write_reg(logic [ckbe_pkg::CFG_IDX_W-1:0] idx,
			logic [ckbe_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				ckbe_pkg::REG_KEY_RED:      key[0] = val[ckbe_pkg::PIX_W-1:0];
				ckbe_pkg::REG_KEY_GREEN:    key[1] = val[ckbe_pkg::PIX_W-1:0];
				ckbe_pkg::REG_KEY_BLUE:     key[2] = val[ckbe_pkg::PIX_W-1:0];
				ckbe_pkg::REG_KEY_ALPHA:    key[3] = val[ckbe_pkg::PIX_W-1:0];
				ckbe_pkg::REG_TOLERANCE:    tol = val[ckbe_pkg::PIX_W-1:0];
				ckbe_pkg::REG_FRAME_WIDTH:  width_reg = val[ckbe_pkg::FW_W-1:0];
				ckbe_pkg::REG_FRAME_HEIGHT: height_reg = val[ckbe_pkg::FH_W-1:0];
				default: ;
			endcase
		endfunction

		// background only if every channel clears key - tolerance, signed
		function bit is_background(rgba_t px);
			int lim;
			for (int c = 0; c < 4; c++) begin
				lim = int'(key[c]) - int'(tol);
				if (!(int'(px[c]) > lim)) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_pixel(rgba_t px);
			int unsigned    w, h, x, y;
			bit             cur, mid, up, left, right, in_core, interior;
			ckbe_pkg::res_t due [$];
			ckbe_pkg::res_t r;
			w = eff_width();
			h = eff_height();
			x = col;
			y = row;
			if (x >= ckbe_pkg::MAX_WIDTH) x = ckbe_pkg::MAX_WIDTH - 1;
			cur = !is_background(px);
			// this pixel settles the one above it
			if (y >= 1) begin
				mid      = fg_above[x];
				up       = fg_two_above[x];
				left     = (x >= 1) ? fg_two_above[x-1] : 1'b0;
				right    = (x + 1 < w && x + 1 < ckbe_pkg::MAX_WIDTH) ? fg_above[x+1] : 1'b0;
				in_core  = x >= 1 && x + 1 < w && y >= 2 && y < h;
				interior = in_core && up && cur && left && right;
				if (mid && !interior) begin
					r.x    = x[ckbe_pkg::XW-1:0];
					r.y    = ckbe_pkg::y_t'(y - 1);
					r.last = 1'b0;
					due    = {due, r};
				end
			end
			fg_two_above[x] = fg_above[x];
			fg_above[x]     = cur;
			// bottom row has no lower neighbour: decided right away
			if (y + 1 >= h && cur) begin
				r.x    = x[ckbe_pkg::XW-1:0];
				r.y    = y[ckbe_pkg::YW-1:0];
				r.last = 1'b0;
				due    = {due, r};
			end
			if (due.size() > 0) due[due.size()-1].last = 1'b1;
			foreach (due[i]) edges_due = {edges_due, due[i]};
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : ((row + 1) & 16'hFFFF);
			end else begin
				col++;
			end
			pixels++;
		endfunction

		function void check_edge(ckbe_pkg::x_t x, ckbe_pkg::y_t y, logic last);
			ckbe_pkg::res_t e;
			int             bad;
			if (edges_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected boundary result x=%0d y=%0d last=%0b",
					$time, x, y, last);
				return;
			end
			e   = edges_due.pop_front();
			bad = 0;
			if (x !== e.x) begin
				bad++;
				$display("%0t: edge_x expected %0d actual %0d", $time, e.x, x);
			end
			if (y !== e.y) begin
				bad++;
				$display("%0t: edge_y expected %0d actual %0d", $time, e.y, y);
			end
			if (last !== e.last) begin
				bad++;
				$display("%0t: last_of_run expected %0b actual %0b", $time, e.last, last);
			end
			if (bad == 0) matched++;
			else errors += bad;
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [ckbe_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ckbe_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic [ckbe_pkg::PIX_W-1:0]      red, green, blue, alpha;
	logic                            out_valid;
	logic                            out_ready;
	logic [ckbe_pkg::XW-1:0]         edge_x;
	logic [ckbe_pkg::YW-1:0]         edge_y;
	logic                            last_of_run;

	edge_scoreboard sb = new();
	bit             jitter_on = 1'b1;  // random idling on both channels
	int             reg_writes = 0;
	int             random_pixels = 0;
	int             phases = 0;
	int             quiet_cycles = 0;

	color_key_boundary_extractor_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.edge_x     (edge_x),
		.edge_y     (edge_y),
		.last_of_run(last_of_run)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: drops ready in about 36% of cycles while jitter is on.
	always @(posedge clk) begin
		out_ready <= jitter_on ? ($urandom_range(99) >= 36) : 1'b1;
	end

	// Monitor and watchdog. Everything is sampled at the edge, before the NBA
	// updates of that edge land, so a transaction is seen exactly where it happens.
	// Results are checked before the pixel of the same edge is noted; a pixel
	// cannot produce a result in the cycle it is taken anyway.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_edge(edge_x, edge_y, last_of_run);
			if (in_valid && in_ready) sb.note_pixel({alpha, blue, green, red});
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, sb.edges_due.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic rgba_t rgba(int r, int g, int b, int a);
		return {a[7:0], b[7:0], g[7:0], r[7:0]};
	endfunction

	// Pixel that lands on the requested side of the current key. Foreground
	// pulls one channel to or below key - tolerance; background lifts all four
	// above it. Where the key leaves no room, the pixel just stays random.
	function automatic rgba_t make_pixel(bit fg);
		rgba_t px;
		int    lim [4];
		int    pick;
		px = $urandom;
		for (int c = 0; c < 4; c++) lim[c] = int'(sb.key[c]) - int'(sb.tol);
		if (fg) begin
			pick = $urandom_range(3);
			if (lim[pick] >= 0)
				px[pick] = ckbe_pkg::PIX_W'($urandom_range(lim[pick], 0));
		end else begin
			for (int c = 0; c < 4; c++)
				if (lim[c] < 255)
					px[c] = ckbe_pkg::PIX_W'($urandom_range(255,
						(lim[c] < 0) ? 0 : lim[c] + 1));
		end
		return px;
	endfunction

	// One register write per clock edge; the scoreboard copy follows at once,
	// which is safe because writes only happen with no pixel in flight.
	task automatic write_reg(logic [ckbe_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[ckbe_pkg::CFG_DATA_W-1:0];
		sb.write_reg(idx, val[ckbe_pkg::CFG_DATA_W-1:0]);
		reg_writes++;
		@(posedge clk);
	endtask

	// Let the unit drain. Pixels with no result can still sit in the input
	// register after the last owed coordinate arrives, so the task keeps
	// waiting once nothing is owed.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.edges_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Holds valid and payload until the transaction completes; optional idle
	// cycles in front of it.
	task automatic send_pixel(rgba_t px);
		while (jitter_on && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red      <= px[0];
		green    <= px[1];
		blue     <= px[2];
		alpha    <= px[3];
		do @(posedge clk); while (!in_ready);
	endtask

	// One random setting followed by (usually) whole frames. The picture is a
	// foreground rectangle on a background field with some flipped pixels and some
	// raw noise, so interior pixels, borders and isolated specks all show up.
	// Now and then the frame is cut short, leaving the next setting to change
	// geometry mid-frame.
	task automatic run_phase();
		int unsigned w_val, h_val, ew, eh, n, cx, cy, span;
		int unsigned rx0, rx1, ry0, ry1;
		bit          fg;
		rgba_t       px;
		settle();
		for (int c = 0; c < 4; c++)
			if ($urandom_range(2) != 0)
				write_reg(KEY_REGS[c], ($urandom_range(3) == 0) ?
					($urandom_range(1) ? 255 : 0) : $urandom_range(255, 128));
		if ($urandom_range(2) != 0)
			write_reg(ckbe_pkg::REG_TOLERANCE, ($urandom_range(3) == 0) ?
				($urandom_range(1) ? 255 : 0) : $urandom_range(40, 0));
		if ($urandom_range(4) != 0) begin
			case ($urandom_range(9))
				0:       w_val = $urandom_range(1);  // zero reads as one
				1:       w_val = ckbe_pkg::MAX_WIDTH;
				default: w_val = $urandom_range(8, 2);
			endcase
			case ($urandom_range(9))
				0:       h_val = 0;
				1:       h_val = 65535;
				2:       h_val = 1;
				default: h_val = $urandom_range(6, 2);
			endcase
			write_reg(ckbe_pkg::REG_FRAME_WIDTH, w_val);
			write_reg(ckbe_pkg::REG_FRAME_HEIGHT, h_val);
		end
		cfg_wr_en <= 1'b0;

		ew = sb.eff_width();
		eh = sb.eff_height();
		n  = ew * eh;
		if (n > 64) n = $urandom_range(64, 8);
		if ($urandom_range(9) == 0) n = $urandom_range(n, 1);
		span = (eh > 8) ? 8 : eh;
		rx0  = $urandom_range(ew / 2);
		rx1  = $urandom_range(ew - 1, rx0);
		ry0  = $urandom_range(span / 2);
		ry1  = $urandom_range(span - 1, ry0);
		cx   = sb.col;
		cy   = sb.row;
		repeat (n) begin
			fg = (cx >= rx0 && cx <= rx1 && cy >= ry0 && cy <= ry1) ?
				($urandom_range(9) != 0) : ($urandom_range(9) == 0);
			px = ($urandom_range(9) == 0) ? rgba_t'($urandom) : make_pixel(fg);
			send_pixel(px);
			if (cx + 1 >= ew) begin
				cx = 0;
				cy = (cy + 1 >= eh) ? 0 : cy + 1;
			end else begin
				cx++;
			end
			random_pixels++;
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		red       <= '0;
		green     <= '0;
		blue      <= '0;
		alpha     <= '0;
		out_ready <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings (key 255, tolerance 15, 2048 wide, one row): every
		// foreground pixel is a bottom-row edge. Threshold is 240, so 241 is the
		// lowest background value and a single low channel is enough for foreground.
		// The first pixel also waits out the line store clearing pass.
		send_pixel(rgba(241, 241, 241, 241));
		send_pixel(rgba(240, 240, 240, 240));
		send_pixel(rgba(255, 255, 255, 255));
		send_pixel(rgba(0, 0, 0, 0));
		send_pixel(rgba(255, 255, 255, 240));

		// Key 0 with tolerance 255: threshold -255, signed compare makes every
		// pixel background. Width and height zero behave as 1x1, and the column
		// left over from above lies beyond the new width.
		settle();
		foreach (KEY_REGS[c]) write_reg(KEY_REGS[c], 0);
		write_reg(ckbe_pkg::REG_TOLERANCE, 255);
		write_reg(ckbe_pkg::REG_FRAME_WIDTH, 0);
		write_reg(ckbe_pkg::REG_FRAME_HEIGHT, 0);
		cfg_wr_en <= 1'b0;
		send_pixel(rgba(0, 0, 0, 0));
		send_pixel(rgba(0, 255, 0, 255));

		// Key 255 with no tolerance: nothing is background. A solid 3x3 frame
		// gives eight border edges; the center is interior and stays silent.
		settle();
		foreach (KEY_REGS[c]) write_reg(KEY_REGS[c], 255);
		write_reg(ckbe_pkg::REG_TOLERANCE, 0);
		write_reg(ckbe_pkg::REG_FRAME_WIDTH, 3);
		write_reg(ckbe_pkg::REG_FRAME_HEIGHT, 3);
		cfg_wr_en <= 1'b0;
		repeat (9) send_pixel(rgba(255, 255, 255, 255));

		// Key 255, tolerance 255: threshold zero, so 1 is background, 0 is not.
		settle();
		write_reg(ckbe_pkg::REG_TOLERANCE, 255);
		cfg_wr_en <= 1'b0;
		send_pixel(rgba(1, 1, 1, 1));
		send_pixel(rgba(1, 1, 0, 1));

		// Oversized width saturates to the full line: a short stretch of a
		// two-row frame on it, foreground first, then a random mix.
		settle();
		write_reg(ckbe_pkg::REG_FRAME_WIDTH, 4095);
		write_reg(ckbe_pkg::REG_FRAME_HEIGHT, 2);
		cfg_wr_en <= 1'b0;
		repeat (2) send_pixel(make_pixel(1'b1));
		repeat (6) send_pixel(make_pixel($urandom_range(1)));

		// Random settings and frames; a run of phases in the middle with no
		// idling on either side.
		while (random_pixels < RANDOM_PIXELS) begin
			jitter_on <= !(phases >= 3 && phases < 8);
			run_phase();
			phases++;
		end

		settle();
		repeat (20) @(posedge clk);
		$display("%0d pixels sent, %0d boundary coordinates matched, %0d errors",
			sb.pixels, sb.matched, sb.errors);
		$display("%0d register writes across %0d random settings plus the directed ones",
			reg_writes, phases);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/ckbe_pkg.sv
design/ckbe_ram.sv
design/color_key_boundary_extractor_unit.sv
tb/tb_top.sv
